FILE: rtl/hace_pkg.sv
// Package for the head attitude channel encoder: constants, register
// indexes and the control word of the serial divider.
// No dependencies; used by hace_div and head_attitude_channel_encoder.
package hace_pkg;

  // Angle scale in decidegrees and channel scale.
  localparam int HalfTurn      = 1800;
  localparam int FullTurn      = 3600;
  localparam int RecenterBase  = HalfTurn + FullTurn;
  localparam int ChMax         = 2047;
  localparam int SwingWindowUs = 500000;

  // Field widths.
  localparam int AngleW = 12;
  localparam int RateW  = 16;
  localparam int TimeW  = 32;
  localparam int ChW    = 11;
  localparam int CountW = 7;
  localparam int AmpW   = 11;
  localparam int MaxW   = 8;

  // Stream and configuration port widths.
  localparam int InDataW  = 88;
  localparam int OutDataW = 40;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 11;

  // Serial divider: numerator, divisor, quotient bits, one bit per cycle.
  localparam int DivNumW  = 25;
  localparam int DivDenW  = 13;
  localparam int DivQuoW  = 12;
  localparam int DivSteps = DivQuoW;
  localparam int StepW    = $clog2(DivSteps);

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CFG_SHAKE_ENABLE   = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_SHAKE_AMP      = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_SHAKE_NEEDED   = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_MAX_ANGLE      = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_SWITCH_PRESENT = 3'd4;

  typedef struct packed {
    logic load;
    logic step;
  } hace_div_ctrl_t;

endpackage

FILE: rtl/hace_div.sv
// Restoring divider that produces one quotient bit per cycle while ctrl_i.step is set.
// Depends on hace_pkg; the numerator must be below divisor * 2**DivQuoW.
module hace_div import hace_pkg::*; (
  input  logic                 clk_i,
  input  hace_div_ctrl_t       ctrl_i,
  input  logic [DivNumW-1:0]   num_i,
  input  logic [DivDenW-1:0]   den_i,
  output logic [DivQuoW-1:0]   quo_o
);

  localparam int ShW = DivDenW + DivSteps - 1;

  logic [DivNumW-1:0] rem_q;
  logic [ShW-1:0]     den_q;
  logic [DivQuoW-1:0] quo_q;
  logic               fits;

  assign fits  = rem_q >= DivNumW'(den_q);
  assign quo_o = quo_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      rem_q <= num_i;
      den_q <= {den_i, {(DivSteps-1){1'b0}}};
      quo_q <= '0;
    end else if (ctrl_i.step) begin
      if (fits) begin
        rem_q <= rem_q - DivNumW'(den_q);
      end
      den_q <= den_q >> 1;
      quo_q <= {quo_q[DivQuoW-2:0], fits};
    end
  end

endmodule

FILE: rtl/head_attitude_channel_encoder.sv
// Channel   | Dir | Word contents (lowest bits first)
// s_axis    | in  | roll, pitch, yaw, yaw rate, time stamp; tuser = switch pressed
// m_axis    | out | roll, pitch, yaw channels; tuser = yaw recentered
// cfg       | in  | register index and write data, always ready
// Each word passes twice through the three bit-serial dividers when the max-angle
// window is on and once when it is off; one divider serves each angle lane, and no
// new input word is accepted until the sequencer is back in idle.
// Reset puts yaw offset at mid scale, clears the swing count and time, and loads
// the register defaults. A finished word waits in the output register while the next
// input word is taken; the sequencer holds before loading it again until it is taken.
// Depends on hace_pkg and hace_div.
module head_attitude_channel_encoder import hace_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,  // roll[11:0] pitch[23:12] yaw[35:24]
                                             // rate[51:36] time_us[83:52]
  input  logic                s_axis_tuser,  // switch_pressed
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,  // roll_ch[10:0] pitch_ch[21:11] yaw_ch[32:22]
  output logic                m_axis_tuser,  // yaw_recentered
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_SHAKE, ST_UPDATE, ST_ANGLE, ST_PREP, ST_DIV1, ST_SCALE, ST_DIV2_OUT
  } state_e;

  localparam int Lanes = 3;

  state_e state_q;
  logic   out_phase_q;
  logic [StepW-1:0] step_q;

  // Configuration registers.
  logic              shake_en_q;
  logic [AmpW-1:0]   amp_q;
  logic [CountW-1:0] needed_q;
  logic [MaxW-1:0]   max_ang_q;
  logic              sw_present_q;

  // Tracking state.
  logic [AngleW-1:0] yaw_off_q, yaw_off_d;
  logic [CountW-1:0] swing_cnt_q, swing_cnt_d;
  logic [TimeW-1:0]  last_time_q, last_time_d;

  // Latched input word.
  logic [AngleW-1:0] roll_q, pitch_q, yaw_q;
  logic [RateW-1:0]  rate_q;
  logic [TimeW-1:0]  time_q;
  logic              pressed_q;

  logic expired_q, pos_q, neg_q, rec_q, rec_d;

  logic              m_valid_q;
  logic [OutDataW-1:0] m_data_q;
  logic              m_user_q;

  // Lane storage.
  logic [AngleW:0]   ang_q   [Lanes];
  logic [AngleW-1:0] c_q     [Lanes];
  logic              use_div_q [Lanes];
  logic              sat_q   [Lanes];

  logic [AngleW:0]   ang_d   [Lanes];
  logic [AngleW-1:0] c_d     [Lanes];
  logic              use_div_d [Lanes];
  logic [AngleW-1:0] c_sel   [Lanes];
  logic [DivNumW-1:0] div_num [Lanes];
  logic [DivDenW-1:0] div_den [Lanes];
  logic [DivQuoW-1:0] quo    [Lanes];
  logic [AngleW+1:0] x_d     [Lanes];
  logic [ChW-1:0]    ch      [Lanes];

  hace_div_ctrl_t div_ctrl;

  logic in_acc;
  logic last_step;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;
  assign last_step     = (step_q == StepW'(DivSteps - 1));

  // Shake detector comparisons and window test.
  logic signed [RateW:0] rate_x, thr_x;
  logic [TimeW-1:0]      dt;
  assign rate_x = signed'({rate_q[RateW-1], rate_q});
  assign thr_x  = signed'({2'b00, amp_q, 4'b0000});
  assign dt     = time_q - last_time_q;

  // New offset puts the present heading at mid scale.
  logic [AngleW:0] off_raw;
  logic [AngleW-1:0] off_new;
  assign off_raw = 13'(RecenterBase) - {1'b0, yaw_q};
  assign off_new = (off_raw >= 13'(FullTurn)) ? AngleW'(off_raw - 13'(FullTurn))
                                               : AngleW'(off_raw);

  logic [CountW-1:0] cnt0, cnt1;
  logic              swing;
  always_comb begin
    cnt0 = expired_q ? '0 : swing_cnt_q;
    swing = cnt0[0] ? pos_q : neg_q;
    cnt1 = swing ? cnt0 + 7'd1 : cnt0;
    swing_cnt_d = swing_cnt_q;
    last_time_d = last_time_q;
    yaw_off_d   = yaw_off_q;
    rec_d       = 1'b0;
    if (shake_en_q) begin
      swing_cnt_d = cnt1;
      if (swing) begin
        last_time_d = time_q;
      end
      if (cnt1 == needed_q) begin
        swing_cnt_d = '0;
        yaw_off_d   = off_new;
        rec_d       = 1'b1;
      end
    end
    if (sw_present_q && pressed_q) begin
      swing_cnt_d = '0;
      yaw_off_d   = off_new;
      rec_d       = 1'b1;
    end
  end

  // Angles shifted to 0..3600; yaw wraps by at most two subtractions.
  logic [AngleW:0] yaw_sum, yaw_r1, yaw_r2;
  always_comb begin
    yaw_sum = {1'b0, yaw_q} + {1'b0, yaw_off_q};
    yaw_r1  = (yaw_sum >= 13'(FullTurn)) ? yaw_sum - 13'(FullTurn) : yaw_sum;
    yaw_r2  = (yaw_r1 >= 13'(FullTurn)) ? yaw_r1 - 13'(FullTurn) : yaw_r1;
    ang_d[0] = {roll_q[AngleW-1], roll_q} + 13'(HalfTurn);
    ang_d[1] = {pitch_q[AngleW-1], pitch_q} + 13'(HalfTurn);
    ang_d[2] = yaw_r2;
  end

  // Stretch window: ten times max angle each side of mid scale.
  logic [AngleW-1:0] ten_m;
  logic [AngleW:0]   span;
  assign ten_m = AngleW'({max_ang_q, 3'b000}) + AngleW'({max_ang_q, 1'b0});
  assign span  = {ten_m, 1'b0};

  always_comb begin
    for (int l = 0; l < Lanes; l++) begin
      x_d[l] = {ang_q[l][AngleW], ang_q[l]} - 14'(HalfTurn) + {2'b00, ten_m};
      use_div_d[l] = 1'b0;
      if (max_ang_q == '0) begin
        if (ang_q[l][AngleW]) begin
          c_d[l] = '0;
        end else if (ang_q[l][AngleW-1:0] > AngleW'(FullTurn)) begin
          c_d[l] = AngleW'(FullTurn);
        end else begin
          c_d[l] = ang_q[l][AngleW-1:0];
        end
      end else if (x_d[l][AngleW+1]) begin
        c_d[l] = '0;
      end else if (x_d[l][AngleW:0] >= span) begin
        c_d[l] = AngleW'(FullTurn);
      end else begin
        c_d[l] = '0;
        use_div_d[l] = 1'b1;
      end
      c_sel[l] = use_div_q[l] ? quo[l] : c_q[l];
      if (state_q == ST_PREP) begin
        div_num[l] = DivNumW'(x_d[l][AngleW:0]) * DivNumW'(FullTurn);
        div_den[l] = span;
      end else begin
        div_num[l] = DivNumW'({c_sel[l], {ChW{1'b0}}});
        div_den[l] = DivDenW'(FullTurn);
      end
      ch[l] = sat_q[l] ? ChW'(ChMax) : quo[l][ChW-1:0];
    end
  end

  assign div_ctrl.load = (state_q == ST_PREP) || (state_q == ST_SCALE);
  assign div_ctrl.step = (state_q == ST_DIV1) ||
                         ((state_q == ST_DIV2_OUT) && !out_phase_q);

  for (genvar l = 0; l < Lanes; l++) begin : g_lane
    hace_div u_div (
      .clk_i  (clk_i),
      .ctrl_i (div_ctrl),
      .num_i  (div_num[l]),
      .den_i  (div_den[l]),
      .quo_o  (quo[l])
    );
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      roll_q    <= s_axis_tdata[11:0];
      pitch_q   <= s_axis_tdata[23:12];
      yaw_q     <= s_axis_tdata[35:24];
      rate_q    <= s_axis_tdata[51:36];
      time_q    <= s_axis_tdata[83:52];
      pressed_q <= s_axis_tuser;
    end
    case (state_q)
      ST_SHAKE: begin
        expired_q <= !dt[TimeW-1] && (dt > TimeW'(SwingWindowUs));
        pos_q     <= rate_x > thr_x;
        neg_q     <= rate_x < -thr_x;
      end
      ST_UPDATE: rec_q <= rec_d;
      ST_ANGLE: begin
        for (int l = 0; l < Lanes; l++) begin
          ang_q[l] <= ang_d[l];
        end
      end
      ST_PREP: begin
        for (int l = 0; l < Lanes; l++) begin
          c_q[l]       <= c_d[l];
          use_div_q[l] <= use_div_d[l];
        end
      end
      ST_SCALE: begin
        for (int l = 0; l < Lanes; l++) begin
          sat_q[l] <= c_sel[l] >= AngleW'(FullTurn);
        end
      end
      default: ;
    endcase
  end

  // Sequencer, configuration, tracking state and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      out_phase_q  <= 1'b0;
      step_q       <= '0;
      shake_en_q   <= 1'b0;
      amp_q        <= AmpW'(300);
      needed_q     <= CountW'(3);
      max_ang_q    <= '0;
      sw_present_q <= 1'b0;
      yaw_off_q    <= AngleW'(HalfTurn);
      swing_cnt_q  <= '0;
      last_time_q  <= '0;
      m_valid_q    <= 1'b0;
      m_data_q     <= '0;
      m_user_q     <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_SHAKE_ENABLE:   shake_en_q   <= cfg_data_i[0];
          CFG_SHAKE_AMP:      amp_q        <= cfg_data_i[AmpW-1:0];
          CFG_SHAKE_NEEDED:   needed_q     <= cfg_data_i[CountW-1:0];
          CFG_MAX_ANGLE:      max_ang_q    <= cfg_data_i[MaxW-1:0];
          CFG_SWITCH_PRESENT: sw_present_q <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            state_q <= ST_SHAKE;
          end
        end
        ST_SHAKE:  state_q <= ST_UPDATE;
        ST_UPDATE: begin
          yaw_off_q   <= yaw_off_d;
          swing_cnt_q <= swing_cnt_d;
          last_time_q <= last_time_d;
          state_q     <= ST_ANGLE;
        end
        ST_ANGLE: state_q <= ST_PREP;
        ST_PREP: begin
          step_q  <= '0;
          state_q <= (max_ang_q != '0) ? ST_DIV1 : ST_SCALE;
        end
        ST_DIV1: begin
          if (last_step) begin
            step_q  <= '0;
            state_q <= ST_SCALE;
          end else begin
            step_q <= step_q + 1'b1;
          end
        end
        ST_SCALE: begin
          step_q      <= '0;
          out_phase_q <= 1'b0;
          state_q     <= ST_DIV2_OUT;
        end
        ST_DIV2_OUT: begin
          if (!out_phase_q) begin
            if (last_step) begin
              out_phase_q <= 1'b1;
            end else begin
              step_q <= step_q + 1'b1;
            end
          end else if (!m_valid_q || m_axis_tready) begin
            // The previous word is gone or leaves this cycle.
            m_valid_q   <= 1'b1;
            m_data_q    <= {7'b0, ch[2], ch[1], ch[0]};
            m_user_q    <= rec_q;
            out_phase_q <= 1'b0;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule
